@@ sv/h2fd_pkg.sv @@
// Shared types and constants for the HTTP/2 frame deframer.
package h2fd_pkg;

  localparam int unsigned MAX_PREFIX_BYTES = 24;
  localparam int unsigned HDR_BYTES        = 9;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_DATA    = 2'd0,
    OP_END     = 2'd1,
    OP_ABANDON = 2'd2
  } op_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_END     = 2'd2,
    KIND_ERROR   = 2'd3
  } kind_e;

  // Error codes
  typedef enum logic [2:0] {
    ERR_NONE            = 3'd0,
    ERR_PREFIX_MISMATCH = 3'd1,
    ERR_END_IN_PREFIX   = 3'd2,
    ERR_PARTIAL_HEADER  = 3'd3,
    ERR_PARTIAL_PAYLOAD = 3'd4
  } err_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_PREFIX_LENGTH = 2'd0,
    CFG_PREFIX_WORD0  = 2'd1,
    CFG_PREFIX_WORD1  = 2'd2,
    CFG_PREFIX_WORD2  = 2'd3
  } cfg_idx_e;

  // Parser phases, one-hot
  typedef enum logic [5:0] {
    PH_PREFIX  = 6'b000001,
    PH_HEADER  = 6'b000010,
    PH_PAYLOAD = 6'b000100,
    PH_SKIP    = 6'b001000,
    PH_ENDED   = 6'b010000,
    PH_ERROR   = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [23:0] frame_length;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [30:0] stream_ident;
    logic [7:0]  payload_byte;
    logic        last_of_payload;
    logic [2:0]  error_code;
  } out_t;

  // Configuration seen by the parser
  typedef struct packed {
    logic [4:0]  prefix_length;
    logic [63:0] prefix_word0;
    logic [63:0] prefix_word1;
    logic [63:0] prefix_word2;
  } cfg_t;

endpackage

@@ sv/http2_frame_deframer.sv @@
// A result passes through the input register and then the result register.
// Throughput: one input transaction per cycle unless the result register stalls; the parser step is combinational.
// Results are held in the result register while out_ready_i is low; input stalls only then.
// Reset (rst_ni low, asynchronous): configuration cleared, parser in prefix phase,
// pipeline empty; a zero prefix length goes straight to frame headers.
module http2_frame_deframer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  h2fd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output h2fd_pkg::out_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [63:0]    cfg_data_i
);

  h2fd_pkg::cfg_t cfg_q;
  logic           item_valid_q;
  h2fd_pkg::in_t  item_q;
  logic           out_valid_q;
  h2fd_pkg::out_t out_q;
  logic           out_free;
  logic           step;
  logic           res_valid;
  h2fd_pkg::out_t res;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        h2fd_pkg::CFG_PREFIX_LENGTH: cfg_q.prefix_length <= cfg_data_i[4:0];
        h2fd_pkg::CFG_PREFIX_WORD0:  cfg_q.prefix_word0  <= cfg_data_i;
        h2fd_pkg::CFG_PREFIX_WORD1:  cfg_q.prefix_word1  <= cfg_data_i;
        h2fd_pkg::CFG_PREFIX_WORD2:  cfg_q.prefix_word2  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Handshake: advance when the result register is empty or being drained
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = item_valid_q && out_free;
  assign in_ready_o = !item_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      item_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= in_data_i;
    end
  end

  h2fd_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (item_q),
    .cfg_i       (cfg_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

@@ sv/h2fd_parse.sv @@
// Per-item parser step: phase state, prefix match, header assembly, payload count.
module h2fd_parse (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  h2fd_pkg::in_t   item_i,
  input  h2fd_pkg::cfg_t  cfg_i,
  output logic            res_valid_o,
  output h2fd_pkg::out_t  res_o
);

  h2fd_pkg::phase_e phase_q, phase_d, phase_eff;
  logic [4:0]  prefix_index_q, prefix_index_d;
  logic [3:0]  header_count_q, header_count_d;
  logic [63:0] header_bytes_q, header_bytes_d;
  logic [23:0] payload_remaining_q, payload_remaining_d;

  logic [4:0]  plen;
  logic [63:0] exp_word;
  logic [7:0]  exp_byte;
  logic [23:0] rem_dec;
  logic [23:0] hdr_len;

  // Clamp the prefix length to the supported maximum
  assign plen = (cfg_i.prefix_length > 5'(h2fd_pkg::MAX_PREFIX_BYTES))
              ? 5'(h2fd_pkg::MAX_PREFIX_BYTES) : cfg_i.prefix_length;

  // Select the expected prefix byte
  always_comb begin
    case (prefix_index_q[4:3])
      2'd0:    exp_word = cfg_i.prefix_word0;
      2'd1:    exp_word = cfg_i.prefix_word1;
      2'd2:    exp_word = cfg_i.prefix_word2;
      default: exp_word = '0;
    endcase
  end
  assign exp_byte = exp_word[{prefix_index_q[2:0], 3'b000} +: 8];

  // A finished prefix behaves as the header phase
  assign phase_eff = ((phase_q == h2fd_pkg::PH_PREFIX) && (prefix_index_q >= plen))
                   ? h2fd_pkg::PH_HEADER : phase_q;

  assign rem_dec = payload_remaining_q - 24'd1;
  assign hdr_len = header_bytes_q[63:40];

  // Next state and result
  always_comb begin
    phase_d             = phase_eff;
    prefix_index_d      = prefix_index_q;
    header_count_d      = header_count_q;
    header_bytes_d      = header_bytes_q;
    payload_remaining_d = payload_remaining_q;
    res_valid_o         = 1'b0;
    res_o               = '0;

    if (phase_eff != h2fd_pkg::PH_ENDED && phase_eff != h2fd_pkg::PH_ERROR) begin
      case (item_i.op)
        h2fd_pkg::OP_ABANDON: begin
          if (phase_eff == h2fd_pkg::PH_PAYLOAD && payload_remaining_q != '0) begin
            phase_d = h2fd_pkg::PH_SKIP;
          end
        end
        h2fd_pkg::OP_END: begin
          res_valid_o = 1'b1;
          res_o.kind  = h2fd_pkg::KIND_ERROR;
          phase_d     = h2fd_pkg::PH_ERROR;
          if (phase_eff == h2fd_pkg::PH_PREFIX) begin
            res_o.error_code = h2fd_pkg::ERR_END_IN_PREFIX;
          end else if (phase_eff == h2fd_pkg::PH_HEADER) begin
            if (header_count_q != '0) begin
              res_o.error_code = h2fd_pkg::ERR_PARTIAL_HEADER;
            end else begin
              res_o.kind = h2fd_pkg::KIND_END;
              phase_d    = h2fd_pkg::PH_ENDED;
            end
          end else begin
            res_o.error_code = h2fd_pkg::ERR_PARTIAL_PAYLOAD;
          end
        end
        h2fd_pkg::OP_DATA: begin
          if (phase_eff == h2fd_pkg::PH_PREFIX) begin
            // Match one prefix byte
            if (item_i.data_byte != exp_byte) begin
              res_valid_o      = 1'b1;
              res_o.kind       = h2fd_pkg::KIND_ERROR;
              res_o.error_code = h2fd_pkg::ERR_PREFIX_MISMATCH;
              phase_d          = h2fd_pkg::PH_ERROR;
            end else begin
              prefix_index_d = prefix_index_q + 5'd1;
              if (prefix_index_d >= plen) begin
                phase_d = h2fd_pkg::PH_HEADER;
              end
            end
          end else if (phase_eff == h2fd_pkg::PH_HEADER) begin
            // Collect header bytes; the ninth completes the header
            if (header_count_q < 4'(h2fd_pkg::HDR_BYTES - 1)) begin
              header_bytes_d = {header_bytes_q[55:0], item_i.data_byte};
              header_count_d = header_count_q + 4'd1;
            end else begin
              res_valid_o          = 1'b1;
              res_o.kind           = h2fd_pkg::KIND_HEADER;
              res_o.frame_length   = hdr_len;
              res_o.frame_type     = header_bytes_q[39:32];
              res_o.frame_flags    = header_bytes_q[31:24];
              res_o.stream_ident   = {header_bytes_q[22:0], item_i.data_byte};
              header_count_d       = '0;
              header_bytes_d       = '0;
              payload_remaining_d  = hdr_len;
              phase_d = (hdr_len != '0) ? h2fd_pkg::PH_PAYLOAD : h2fd_pkg::PH_HEADER;
            end
          end else if (phase_eff == h2fd_pkg::PH_PAYLOAD) begin
            // Pass one payload byte on
            payload_remaining_d = rem_dec;
            res_valid_o         = 1'b1;
            res_o.kind          = h2fd_pkg::KIND_PAYLOAD;
            res_o.payload_byte  = item_i.data_byte;
            if (rem_dec == '0) begin
              res_o.last_of_payload = 1'b1;
              phase_d               = h2fd_pkg::PH_HEADER;
            end
          end else if (phase_eff == h2fd_pkg::PH_SKIP) begin
            // Drop one abandoned payload byte
            payload_remaining_d = rem_dec;
            if (rem_dec == '0) begin
              phase_d = h2fd_pkg::PH_HEADER;
            end
          end
        end
        default: begin
          // Unused code: no result; only the prefix-complete move applies
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q             <= h2fd_pkg::PH_PREFIX;
      prefix_index_q      <= '0;
      header_count_q      <= '0;
      header_bytes_q      <= '0;
      payload_remaining_q <= '0;
    end else if (step_i) begin
      phase_q             <= phase_d;
      prefix_index_q      <= prefix_index_d;
      header_count_q      <= header_count_d;
      header_bytes_q      <= header_bytes_d;
      payload_remaining_q <= payload_remaining_d;
    end
  end

endmodule
